@@ rtl/btpc_pkg.sv @@
// Package for the barometric temperature and pressure compensation block.
// Holds the register index codes, stream widths and fixed constants.
// No dependencies.
package btpc_pkg;

   localparam int NUM_STAGES   = 10;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 56;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS_T1  = 3'd0,
      CSR_OFF_T1   = 3'd1,
      CSR_TCS      = 3'd2,
      CSR_TCO      = 3'd3,
      CSR_T_REF    = 3'd4,
      CSR_TEMPSENS = 3'd5
   } csr_index_type;

   localparam logic signed [18:0] TEMP_BASE  = 19'sd2000;
   localparam logic signed [18:0] TEMP_COLD  = 19'sd2000;
   localparam logic signed [18:0] TEMP_VCOLD = -19'sd1500;
   localparam logic signed [19:0] E_COLD     = 20'sd2000;
   localparam logic signed [19:0] E_VCOLD    = 20'sd1500;
   localparam logic signed [19:0] TC_MAX     = 20'sd262143;
   localparam logic signed [19:0] TC_MIN     = -20'sd262144;

endpackage

@@ rtl/baro_temp_pressure_compensation.sv @@
// Top level of the barometric temperature and pressure compensation block.
// Ten-stage pipeline with second-order cold correction and saturation.
// Depends on btpc_pkg.

// Each request carries one raw pressure (D1) and one raw temperature (D2)
// conversion and produces exactly one response once it has passed every
// stage, with one request taken every cycle when the response side keeps
// up. The pipeline depth is set by the chain of multiplications: first-order
// products, the squared temperature errors, and the 24 by 42 bit pressure
// product split into two partial products that are summed a stage later.
// Every stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so a stalled response fills bubbles behind it and the
// request side stays ready until the pipeline is full. Coefficients C1..C6
// are written through the csr port (index 0..5, other indexes ignored) by
// the user only while no request is in flight; the block does not enforce
// it. A raw value of zero gives zero outputs with zero_read set in rsp_tuser.
module baro_temp_pressure_compensation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [23:0] raw_pressure, [47:24] raw_temperature
   input  logic [btpc_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [18:0] temperature_centi, [50:19] pressure_pa, [55:51] zero
   output logic [btpc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] zero_read
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [btpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [btpc_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [15:0] sens_t1_ff, off_t1_ff, tcs_ff, tco_ff, t_ref_ff, tempsens_ff;

   logic [btpc_pkg::NUM_STAGES-1:0] stage_vld_ff, stage_vld_in, stage_ld;

   // stage 1
   logic [23:0]        s1_d1_ff;
   logic signed [24:0] s1_dt_ff, s1_dt_in;
   logic               s1_zr_ff, s1_zr_in;
   // stage 2
   logic [23:0]        s2_d1_ff;
   logic               s2_zr_ff;
   logic signed [40:0] s2_pt_ff, s2_pt_in, s2_po_ff, s2_po_in, s2_ps_ff, s2_ps_in;
   logic signed [49:0] s2_sq;
   logic [47:0]        s2_dd_ff, s2_dd_in;
   // stage 3
   logic [23:0]        s3_d1_ff;
   logic               s3_zr_ff;
   logic signed [18:0] s3_temp_ff, s3_temp_in;
   logic [49:0]        s3_dd3;
   logic [50:0]        s3_dd5;
   logic [16:0]        s3_t2c_ff, s3_t2c_in, s3_t2w_ff, s3_t2w_in;
   logic signed [35:0] s3_offb_ff, s3_offb_in;
   logic signed [34:0] s3_sensb_ff, s3_sensb_in;
   // stage 4
   logic [23:0]        s4_d1_ff;
   logic               s4_zr_ff;
   logic signed [35:0] s4_offb_ff;
   logic signed [34:0] s4_sensb_ff;
   logic signed [19:0] s4_e, s4_e2, s4_tc_ff, s4_tc_in;
   logic signed [39:0] s4_esq_full, s4_e2sq_full;
   logic [33:0]        s4_esq_ff, s4_esq_in;
   logic [35:0]        s4_e2sq_ff, s4_e2sq_in;
   logic               s4_cold_ff, s4_cold_in, s4_vcold_ff, s4_vcold_in;
   // stage 5
   logic [23:0]        s5_d1_ff;
   logic               s5_zr_ff;
   logic signed [35:0] s5_offb_ff;
   logic signed [34:0] s5_sensb_ff;
   logic [39:0]        s5_m61;
   logic [40:0]        s5_m17;
   logic [38:0]        s5_m29;
   logic [39:0]        s5_m9;
   logic [41:0]        s5_off2_ff, s5_off2_in;
   logic [40:0]        s5_sens2_ff, s5_sens2_in;
   logic signed [18:0] s5_tc_ff, s5_tc_in;
   // stage 6
   logic [23:0]        s6_d1_ff;
   logic               s6_zr_ff;
   logic signed [18:0] s6_tc_ff;
   logic signed [42:0] s6_off_ff, s6_off_in;
   logic signed [41:0] s6_sens_ff, s6_sens_in;
   // stage 7
   logic               s7_zr_ff;
   logic signed [18:0] s7_tc_ff;
   logic signed [42:0] s7_off_ff;
   logic [44:0]        s7_pl_ff, s7_pl_in;
   logic signed [45:0] s7_ph_ff, s7_ph_in;
   // stage 8
   logic               s8_zr_ff;
   logic signed [18:0] s8_tc_ff;
   logic signed [42:0] s8_off_ff;
   logic signed [66:0] s8_prod_ff, s8_prod_in;
   // stage 9
   logic               s9_zr_ff;
   logic signed [18:0] s9_tc_ff;
   logic signed [46:0] s9_q_ff, s9_q_in;
   // stage 10
   logic               s10_zr_ff;
   logic [18:0]        s10_tc_ff, s10_tc_in;
   logic [31:0]        s10_p_ff, s10_p_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_t1_ff  <= '0;
         off_t1_ff   <= '0;
         tcs_ff      <= '0;
         tco_ff      <= '0;
         t_ref_ff    <= '0;
         tempsens_ff <= '0;
      end else if (csr_valid) begin
         unique case (btpc_pkg::csr_index_type'(csr_index))
            btpc_pkg::CSR_SENS_T1:  sens_t1_ff  <= csr_data;
            btpc_pkg::CSR_OFF_T1:   off_t1_ff   <= csr_data;
            btpc_pkg::CSR_TCS:      tcs_ff      <= csr_data;
            btpc_pkg::CSR_TCO:      tco_ff      <= csr_data;
            btpc_pkg::CSR_T_REF:    t_ref_ff    <= csr_data;
            btpc_pkg::CSR_TEMPSENS: tempsens_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline flow control
   always_comb begin
      stage_ld[btpc_pkg::NUM_STAGES-1] = !stage_vld_ff[btpc_pkg::NUM_STAGES-1] || rsp_tready;
      for (int k = btpc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         stage_ld[k] = !stage_vld_ff[k] || stage_ld[k+1];
      end
      stage_vld_in = {stage_vld_ff[btpc_pkg::NUM_STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
      end else begin
         for (int k = 0; k < btpc_pkg::NUM_STAGES; k++) begin
            if (stage_ld[k]) begin
               stage_vld_ff[k] <= stage_vld_in[k];
            end
         end
      end
   end

   assign req_tready = stage_ld[0];
   assign rsp_tvalid = stage_vld_ff[btpc_pkg::NUM_STAGES-1];
   assign rsp_tdata  = {5'b0, s10_p_ff, s10_tc_ff};
   assign rsp_tuser  = s10_zr_ff;

   // datapath
   always_comb begin
      s1_dt_in = $signed({1'b0, req_tdata[47:24]}) - $signed({1'b0, t_ref_ff, 8'b0});
      s1_zr_in = (req_tdata[23:0] == 24'd0) || (req_tdata[47:24] == 24'd0);

      s2_pt_in = s1_dt_ff * $signed({1'b0, tempsens_ff});
      s2_po_in = s1_dt_ff * $signed({1'b0, tco_ff});
      s2_ps_in = s1_dt_ff * $signed({1'b0, tcs_ff});
      s2_sq    = s1_dt_ff * s1_dt_ff;
      s2_dd_in = s2_sq[47:0];

      s3_temp_in  = $signed({s2_pt_ff[40], s2_pt_ff[40:23]}) + btpc_pkg::TEMP_BASE;
      s3_dd3      = {1'b0, s2_dd_ff, 1'b0} + {2'b0, s2_dd_ff};
      s3_dd5      = {1'b0, s2_dd_ff, 2'b0} + {3'b0, s2_dd_ff};
      s3_t2c_in   = s3_dd3[49:33];
      s3_t2w_in   = {4'b0, s3_dd5[50:38]};
      s3_offb_in  = $signed({3'b0, off_t1_ff, 17'b0})
                  + $signed({s2_po_ff[40], s2_po_ff[40:6]});
      s3_sensb_in = $signed({3'b0, sens_t1_ff, 16'b0})
                  + $signed({s2_ps_ff[40], s2_ps_ff[40:7]});

      s4_e         = $signed({s3_temp_ff[18], s3_temp_ff}) - btpc_pkg::E_COLD;
      s4_e2        = $signed({s3_temp_ff[18], s3_temp_ff}) + btpc_pkg::E_VCOLD;
      s4_esq_full  = s4_e * s4_e;
      s4_e2sq_full = s4_e2 * s4_e2;
      s4_esq_in    = s4_esq_full[33:0];
      s4_e2sq_in   = s4_e2sq_full[35:0];
      s4_cold_in   = s3_temp_ff < btpc_pkg::TEMP_COLD;
      s4_vcold_in  = s3_temp_ff < btpc_pkg::TEMP_VCOLD;
      s4_tc_in     = $signed({s3_temp_ff[18], s3_temp_ff})
                   - $signed({3'b0, (s4_cold_in ? s3_t2c_ff : s3_t2w_ff)});

      s5_m61 = {s4_esq_ff, 6'b0} - {4'b0, s4_esq_ff, 2'b0} + {6'b0, s4_esq_ff};
      s5_m17 = {1'b0, s4_e2sq_ff, 4'b0} + {5'b0, s4_e2sq_ff};
      s5_m29 = {s4_esq_ff, 5'b0} - {4'b0, s4_esq_ff, 1'b0} - {5'b0, s4_esq_ff};
      s5_m9  = {1'b0, s4_e2sq_ff, 3'b0} + {4'b0, s4_e2sq_ff};
      if (s4_cold_ff) begin
         s5_off2_in  = {6'b0, s5_m61[39:4]} + (s4_vcold_ff ? {1'b0, s5_m17} : 42'd0);
         s5_sens2_in = {6'b0, s5_m29[38:4]} + (s4_vcold_ff ? {1'b0, s5_m9} : 41'd0);
      end else begin
         s5_off2_in  = '0;
         s5_sens2_in = '0;
      end
      if (s4_tc_ff > btpc_pkg::TC_MAX) begin
         s5_tc_in = btpc_pkg::TC_MAX[18:0];
      end else if (s4_tc_ff < btpc_pkg::TC_MIN) begin
         s5_tc_in = btpc_pkg::TC_MIN[18:0];
      end else begin
         s5_tc_in = s4_tc_ff[18:0];
      end

      s6_off_in  = $signed({{7{s5_offb_ff[35]}}, s5_offb_ff}) - $signed({1'b0, s5_off2_ff});
      s6_sens_in = $signed({{7{s5_sensb_ff[34]}}, s5_sensb_ff}) - $signed({1'b0, s5_sens2_ff});

      s7_pl_in = s6_d1_ff * s6_sens_ff[20:0];
      s7_ph_in = $signed({1'b0, s6_d1_ff}) * $signed(s6_sens_ff[41:21]);

      s8_prod_in = $signed({s7_ph_ff, 21'b0}) + $signed({22'b0, s7_pl_ff});

      s9_q_in = $signed({s8_prod_ff[66], s8_prod_ff[66:21]})
              - $signed({{4{s8_off_ff[42]}}, s8_off_ff});

      s10_tc_in = s9_zr_ff ? 19'd0 : s9_tc_ff;
      s10_p_in  = s9_zr_ff ? 32'd0 : s9_q_ff[46:15];
   end

   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         s1_d1_ff <= req_tdata[23:0];
         s1_dt_ff <= s1_dt_in;
         s1_zr_ff <= s1_zr_in;
      end
      if (stage_ld[1]) begin
         s2_d1_ff <= s1_d1_ff;
         s2_zr_ff <= s1_zr_ff;
         s2_pt_ff <= s2_pt_in;
         s2_po_ff <= s2_po_in;
         s2_ps_ff <= s2_ps_in;
         s2_dd_ff <= s2_dd_in;
      end
      if (stage_ld[2]) begin
         s3_d1_ff    <= s2_d1_ff;
         s3_zr_ff    <= s2_zr_ff;
         s3_temp_ff  <= s3_temp_in;
         s3_t2c_ff   <= s3_t2c_in;
         s3_t2w_ff   <= s3_t2w_in;
         s3_offb_ff  <= s3_offb_in;
         s3_sensb_ff <= s3_sensb_in;
      end
      if (stage_ld[3]) begin
         s4_d1_ff    <= s3_d1_ff;
         s4_zr_ff    <= s3_zr_ff;
         s4_offb_ff  <= s3_offb_ff;
         s4_sensb_ff <= s3_sensb_ff;
         s4_esq_ff   <= s4_esq_in;
         s4_e2sq_ff  <= s4_e2sq_in;
         s4_cold_ff  <= s4_cold_in;
         s4_vcold_ff <= s4_vcold_in;
         s4_tc_ff    <= s4_tc_in;
      end
      if (stage_ld[4]) begin
         s5_d1_ff    <= s4_d1_ff;
         s5_zr_ff    <= s4_zr_ff;
         s5_offb_ff  <= s4_offb_ff;
         s5_sensb_ff <= s4_sensb_ff;
         s5_off2_ff  <= s5_off2_in;
         s5_sens2_ff <= s5_sens2_in;
         s5_tc_ff    <= s5_tc_in;
      end
      if (stage_ld[5]) begin
         s6_d1_ff   <= s5_d1_ff;
         s6_zr_ff   <= s5_zr_ff;
         s6_tc_ff   <= s5_tc_ff;
         s6_off_ff  <= s6_off_in;
         s6_sens_ff <= s6_sens_in;
      end
      if (stage_ld[6]) begin
         s7_zr_ff  <= s6_zr_ff;
         s7_tc_ff  <= s6_tc_ff;
         s7_off_ff <= s6_off_ff;
         s7_pl_ff  <= s7_pl_in;
         s7_ph_ff  <= s7_ph_in;
      end
      if (stage_ld[7]) begin
         s8_zr_ff   <= s7_zr_ff;
         s8_tc_ff   <= s7_tc_ff;
         s8_off_ff  <= s7_off_ff;
         s8_prod_ff <= s8_prod_in;
      end
      if (stage_ld[8]) begin
         s9_zr_ff <= s8_zr_ff;
         s9_tc_ff <= s8_tc_ff;
         s9_q_ff  <= s9_q_in;
      end
      if (stage_ld[9]) begin
         s10_zr_ff <= s9_zr_ff;
         s10_tc_ff <= s10_tc_in;
         s10_p_ff  <= s10_p_in;
      end
   end

endmodule

@@ verif/baro_temp_pressure_compensation_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for baro_temp_pressure_compensation: streams raw D1/D2
// pairs under several coefficient sets and checks each response field by field.
// Depends on btpc_pkg and the block RTL; needs no files or arguments.
module baro_temp_pressure_compensation_test;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 12;
   localparam int NUM_COEFS    = 6;
   localparam int RANDOM_ITEMS = 190;
   localparam int QUIET_LIMIT  = 4000;
   localparam int MAX_REPORTS  = 10;
   localparam logic [btpc_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [btpc_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [23:0] RAW_MAX = 24'hFFFFFF;
   localparam logic [15:0] TYPICAL_COEFS [NUM_COEFS] =
      '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};

   typedef enum int {
      SET_TYPICAL,
      SET_ALL_MAX,
      SET_ALL_ZERO,
      SET_ALT_HIGH,
      SET_ALT_LOW,
      SET_NEAR_TYPICAL,
      SET_RANDOM
   } coef_set_type;

   localparam coef_set_type SWEEP_SETS [7] = '{SET_ALL_MAX, SET_ALL_ZERO, SET_ALT_HIGH,
      SET_ALT_LOW, SET_NEAR_TYPICAL, SET_RANDOM, SET_RANDOM};

   typedef struct packed {
      logic [18:0] temperature_centi;
      logic [31:0] pressure_pa;
      logic        zero_read;
   } reading_type;

   class compensation_scoreboard;
      logic [15:0] sens_t1  = '0;
      logic [15:0] off_t1   = '0;
      logic [15:0] tcs      = '0;
      logic [15:0] tco      = '0;
      logic [15:0] t_ref    = '0;
      logic [15:0] tempsens = '0;
      reading_type expected_readings [$];
      int requests       = 0;
      int responses      = 0;
      int mismatches     = 0;
      int warm_hits      = 0;
      int cold_hits      = 0;
      int very_cold_hits = 0;
      int zero_hits      = 0;

      function void note_config(logic [btpc_pkg::CSR_IDX_W-1:0] index, logic [15:0] value);
         case (index)
            btpc_pkg::CSR_SENS_T1:  sens_t1  = value;
            btpc_pkg::CSR_OFF_T1:   off_t1   = value;
            btpc_pkg::CSR_TCS:      tcs      = value;
            btpc_pkg::CSR_TCO:      tco      = value;
            btpc_pkg::CSR_T_REF:    t_ref    = value;
            btpc_pkg::CSR_TEMPSENS: tempsens = value;
            default: ;
         endcase
      endfunction

      function reading_type compensate(logic [23:0] d1, logic [23:0] d2);
         reading_type r;
         longint dt, temp, err, t2, off2, sens2, off, sens, p, tc;
         r = '0;
         if (d1 == 0 || d2 == 0) begin
            zero_hits++;
            r.zero_read = 1'b1;
            return r;
         end
         dt   = longint'(d2) - longint'(t_ref) * 256;
         temp = 2000 + ((dt * longint'(tempsens)) >>> 23);
         if (temp < 2000) begin
            err   = temp - 2000;
            t2    = (3 * dt * dt) >>> 33;
            off2  = (61 * err * err) / 16;
            sens2 = (29 * err * err) / 16;
            if (temp < -1500) begin
               very_cold_hits++;
               err   = temp + 1500;
               off2  += 17 * err * err;
               sens2 += 9 * err * err;
            end else begin
               cold_hits++;
            end
         end else begin
            warm_hits++;
            t2    = (5 * dt * dt) >>> 38;
            off2  = 0;
            sens2 = 0;
         end
         off  = longint'(off_t1) * 131072 + ((longint'(tco) * dt) >>> 6) - off2;
         sens = longint'(sens_t1) * 65536 + ((longint'(tcs) * dt) >>> 7) - sens2;
         p    = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
         tc   = temp - t2;
         if (tc > 262143) tc = 262143;
         else if (tc < -262144) tc = -262144;
         if (p > 64'sd2147483647) p = 64'sd2147483647;
         else if (p < -64'sd2147483648) p = -64'sd2147483648;
         r.temperature_centi = tc[18:0];
         r.pressure_pa       = p[31:0];
         return r;
      endfunction

      function void note_request(logic [23:0] d1, logic [23:0] d2);
         requests++;
         expected_readings.push_back(compensate(d1, d2));
      endfunction

      function void compare_field(string field, longint want, longint got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: response %0d %s expected %0d got %0d",
                        responses, field, want, got);
         end
      endfunction

      function void check_response(logic [btpc_pkg::RSP_DATA_W-1:0] data, logic zero_flag);
         reading_type want;
         responses++;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: response %0d arrived with no request outstanding",
                        responses);
            return;
         end
         want = expected_readings.pop_front();
         compare_field("temperature_centi", $signed(want.temperature_centi),
                       $signed(data[18:0]));
         compare_field("pressure_pa", $signed(want.pressure_pa), $signed(data[50:19]));
         compare_field("zero_read", want.zero_read, zero_flag);
         compare_field("tdata padding", 0, data[btpc_pkg::RSP_DATA_W-1:51]);
      endfunction
   endclass

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [btpc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [btpc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [btpc_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [btpc_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   compensation_scoreboard sb;
   bit          req_steady      = 1'b0;
   bit          rsp_steady      = 1'b1;
   int unsigned rsp_stall       = 0;
   int unsigned rsp_mode_cycles = 0;
   int unsigned quiet_cycles    = 0;
   int          coef_sets       = 1;

   baro_temp_pressure_compensation dut (.*);

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 0;
   end

   function automatic int unsigned draw_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [23:0] draw_pressure_raw();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return 24'd0;
      if (roll < 8) return (roll < 6) ? RAW_MAX : 24'd1;
      if (roll < 50) return 24'($urandom_range(4000000, 10000000));
      return 24'($urandom);
   endfunction

   // bias D2 around the reference point so cold and very cold ranges get hit
   function automatic logic [23:0] draw_temperature_raw(logic [15:0] t_ref);
      int unsigned roll;
      longint centre, value;
      roll   = $urandom_range(0, 99);
      centre = longint'(t_ref) * 256;
      if (roll < 3) return 24'd0;
      if (roll < 8) return (roll < 6) ? RAW_MAX : 24'd1;
      if (roll >= 65) return 24'($urandom);
      if (roll < 45)
         value = centre + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
      else
         value = centre - longint'($urandom_range(0, 1 << 24));
      if (value < 1) value = 1;
      else if (value > longint'(RAW_MAX)) value = longint'(RAW_MAX);
      return value[23:0];
   endfunction

   always @(posedge clock) begin
      if (rsp_mode_cycles == 0) begin
         rsp_steady      = ($urandom_range(0, 3) == 0);
         rsp_mode_cycles = $urandom_range(30, 300);
      end else begin
         rsp_mode_cycles--;
      end
      if (rsp_steady) begin
         rsp_stall = 0;
         rsp_tready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_stall = draw_gap();
         rsp_tready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
            $display("baro_temp_pressure_compensation verification failed");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [23:0] d1, input logic [23:0] d2);
      int unsigned gap;
      gap = req_steady ? 0 : draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {16'($urandom), 32'($urandom)};
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d2, d1};
      do @(posedge clock); while (!req_tready);
      sb.note_request(d1, d2);
   endtask

   task automatic write_csr(input logic [btpc_pkg::CSR_IDX_W-1:0] index,
                            input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.note_config(index, value);
   endtask

   task automatic program_coefficients(input coef_set_type kind);
      logic [15:0] coefs [NUM_COEFS];
      int unsigned start;
      btpc_pkg::csr_index_type index;
      for (int i = 0; i < NUM_COEFS; i++) begin
         case (kind)
            SET_TYPICAL:      coefs[i] = TYPICAL_COEFS[i];
            SET_ALL_MAX:      coefs[i] = 16'hFFFF;
            SET_ALL_ZERO:     coefs[i] = 16'h0000;
            SET_ALT_HIGH:     coefs[i] = i[0] ? 16'h0000 : 16'hFFFF;
            SET_ALT_LOW:      coefs[i] = i[0] ? 16'hFFFF : 16'h0000;
            SET_NEAR_TYPICAL:
               coefs[i] = TYPICAL_COEFS[i] + 16'($urandom_range(0, 4096)) - 16'd2048;
            default:          coefs[i] = 16'($urandom);
         endcase
      end
      start = $urandom_range(0, NUM_COEFS - 1);
      for (int k = 0; k < NUM_COEFS; k++) begin
         index = btpc_pkg::csr_index_type'((start + k) % NUM_COEFS);
         write_csr(index, coefs[index]);
      end
      // spare indexes must not disturb any coefficient
      if ($urandom_range(0, 1) == 1) write_csr(CSR_SPARE_LO, 16'($urandom));
      write_csr(CSR_SPARE_HI, 16'($urandom));
      csr_valid <= 1'b0;
      coef_sets++;
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (sb.expected_readings.size() != 0) @(posedge clock);
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_request(24'd0, 24'd5);
      send_request(RAW_MAX, RAW_MAX);
      send_request(24'd1, 24'd1);
      send_request(24'h5A5A5A, 24'd0);
      drain_requests();

      program_coefficients(SET_TYPICAL);
      send_request(24'd6465444, 24'd8077636);
      send_request(24'd6465444, 24'd8077568);
      send_request(24'd6465444, 24'd8077567);
      send_request(24'd6465444, 24'd7500000);
      send_request(24'd6465444, 24'd7035136);
      send_request(24'd6465444, 24'd7035134);
      send_request(24'd6465444, 24'd1);
      send_request(RAW_MAX, 24'd1);
      send_request(24'd1, RAW_MAX);
      send_request(RAW_MAX, RAW_MAX);
      send_request(24'd1, 24'd1);
      send_request(24'd0, 24'd8077636);
      send_request(24'd6465444, 24'd0);
      send_request(24'd0, 24'd0);
      send_request(24'hAAAAAA, 24'h555555);
      send_request(24'h555555, 24'hAAAAAA);
      drain_requests();

      foreach (SWEEP_SETS[s]) begin
         program_coefficients(SWEEP_SETS[s]);
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) req_steady = ($urandom_range(0, 3) == 0);
            send_request(draw_pressure_raw(), draw_temperature_raw(sb.t_ref));
         end
         drain_requests();
      end

      // hold a little longer to catch stray responses
      repeat (2 * btpc_pkg::NUM_STAGES) @(posedge clock);

      $display("Run covered %0d requests over %0d coefficient sets: %0d warm, %0d cold,",
               sb.requests, coef_sets, sb.warm_hits, sb.cold_hits);
      $display("%0d very cold, %0d zero reads; %0d responses checked, %0d mismatches.",
               sb.very_cold_hits, sb.zero_hits, sb.responses, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_readings.size() == 0)
         $display("baro_temp_pressure_compensation verification clean");
      else
         $display("baro_temp_pressure_compensation verification failed");
      $finish;
   end

endmodule
